@@ rtl/akl_pkg.sv @@
package akl_pkg;

    // Field widths of the channel payloads.
    localparam int SAMPLE_W = 10;
    localparam int KEY_W    = 3;
    localparam int SUM_W    = 13;

    // Largest sample code, the empty-window minimum.
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(1000);
    localparam logic [SAMPLE_W-1:0] MARGIN_RESET    = SAMPLE_W'(10);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_RELEASE_THRESHOLD = 1'b0,
        CFG_SPREAD_MARGIN     = 1'b1
    } t_cfg_idx;

    // Calibration phases, one-hot.
    typedef enum logic [3:0] {
        PH_WAIT_RELEASE    = 4'b0001,
        PH_CONFIRM_RELEASE = 4'b0010,
        PH_WAIT_PRESS      = 4'b0100,
        PH_COLLECT         = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
    } t_sample_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [KEY_W-1:0]    key_index;
        logic                last_key;
    } t_result;

    typedef struct packed {
        t_cfg_idx            index;
        logic [SAMPLE_W-1:0] wdata;
    } t_cfg_req;

endpackage

@@ rtl/akl_chan_if.sv @@
interface akl_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/analog_key_level_calibrator.sv @@
// Analog key level calibrator for a resistor-ladder keypad.
// i_sample carries one 10-bit ADC reading per request. For each key the block
// waits for two successive readings above the release threshold, then for a
// reading below it, then collects a window of WINDOW_LEN readings. A window
// whose spread is within the margin yields one request on o_result: the
// truncated window average, the key number and a flag on the final key.
// i_cfg writes the release threshold (index 0) and spread margin (index 1);
// it is always ready and should be used only while the block is idle.
// Throughput is one sample per cycle but for the stall described below. A
// sample passes an input register, a state-update stage and a
// divide-by-constant multiply stage, which registers the result.
// A stalled o_result holds its request; samples that produce no result keep
// flowing, and only a sample that completes a window waits for the middle
// stage to drain. Synchronous reset returns to the release wait with key 0,
// restores the register defaults and empties the pipeline.
module analog_key_level_calibrator #(
    parameter int WINDOW_LEN = 6,
    parameter int KEY_COUNT  = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    akl_chan_if.sink   i_sample,
    akl_chan_if.sink   i_cfg,
    akl_chan_if.source o_result
);

    localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int RECIP     = (2 ** DIV_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W    = akl_pkg::SUM_W + RECIP_W;

    localparam logic [CNT_W-1:0]         CNT_FULL = CNT_W'(WINDOW_LEN);
    localparam logic [akl_pkg::KEY_W-1:0] KEY_LAST = akl_pkg::KEY_W'(KEY_COUNT - 1);
    localparam logic [RECIP_W-1:0]       RECIP_C  = RECIP_W'(RECIP);

    // Configuration registers.
    logic [akl_pkg::SAMPLE_W-1:0] r_threshold;
    logic [akl_pkg::SAMPLE_W-1:0] r_margin;

    // Input register.
    logic                         r_in_valid;
    logic [akl_pkg::SAMPLE_W-1:0] r_in_sample;

    // Calibration state.
    akl_pkg::t_phase              r_phase, n_phase;
    logic [akl_pkg::SAMPLE_W-1:0] r_min, n_min;
    logic [akl_pkg::SAMPLE_W-1:0] r_max, n_max;
    logic [akl_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [akl_pkg::KEY_W-1:0]    r_key, n_key;

    // Middle stage: a finished window waiting for its division.
    logic                         r_mid_valid;
    logic [akl_pkg::SUM_W-1:0]    r_mid_sum;
    logic [akl_pkg::KEY_W-1:0]    r_mid_key;
    logic                         r_mid_last;

    // Output register.
    logic                         r_out_valid;
    akl_pkg::t_result             r_out;

    logic                         out_free;
    logic                         mid_free;
    logic                         emit;
    logic                         a_go;
    logic                         in_take;
    logic [akl_pkg::SAMPLE_W-1:0] s;
    logic                         s_above;
    logic                         s_below;
    logic [akl_pkg::SAMPLE_W-1:0] win_min;
    logic [akl_pkg::SAMPLE_W-1:0] win_max;
    logic [akl_pkg::SUM_W-1:0]    win_sum;
    logic [CNT_W-1:0]             win_count;
    logic                         win_full;
    logic                         spread_ok;
    logic [PROD_W-1:0]            product;

    // Configuration writes are taken at once.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= akl_pkg::THRESHOLD_RESET;
            r_margin    <= akl_pkg::MARGIN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                akl_pkg::CFG_RELEASE_THRESHOLD: r_threshold <= i_cfg.data.wdata;
                akl_pkg::CFG_SPREAD_MARGIN:     r_margin    <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // Stage handshakes: each stage moves when the one after it has room.
    assign out_free       = !r_out_valid || o_result.ready;
    assign mid_free       = !r_mid_valid || out_free;
    assign a_go           = r_in_valid && (!emit || mid_free);
    assign in_take        = !r_in_valid || a_go;
    assign i_sample.ready = in_take;

    // Window statistics including the current sample.
    assign s         = r_in_sample;
    assign s_above   = s > r_threshold;
    assign s_below   = s < r_threshold;
    assign win_min   = (s < r_min) ? s : r_min;
    assign win_max   = (s > r_max) ? s : r_max;
    assign win_sum   = r_sum + akl_pkg::SUM_W'(s);
    assign win_count = r_count + CNT_W'(1);
    assign win_full  = win_count == CNT_FULL;
    assign spread_ok = (win_max - win_min) <= r_margin;
    assign emit      = r_in_valid && (r_phase == akl_pkg::PH_COLLECT) && !s_above
                       && win_full && spread_ok;

    // Next calibration state for the sample in the input register.
    always_comb begin
        n_phase = r_phase;
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_count = r_count;
        n_key   = r_key;
        unique case (r_phase)
            akl_pkg::PH_WAIT_RELEASE: begin
                if (s_above) begin
                    n_phase = akl_pkg::PH_CONFIRM_RELEASE;
                end
            end
            akl_pkg::PH_CONFIRM_RELEASE: begin
                n_phase = s_above ? akl_pkg::PH_WAIT_PRESS : akl_pkg::PH_WAIT_RELEASE;
            end
            akl_pkg::PH_WAIT_PRESS: begin
                if (s_below) begin
                    n_phase = akl_pkg::PH_COLLECT;
                    n_min   = akl_pkg::SAMPLE_MAX;
                    n_max   = '0;
                    n_sum   = '0;
                    n_count = '0;
                end
            end
            akl_pkg::PH_COLLECT: begin
                if (s_above || (win_full && !spread_ok)) begin
                    // Released mid-window or too noisy: wait for a new press.
                    n_phase = akl_pkg::PH_WAIT_PRESS;
                    n_min   = akl_pkg::SAMPLE_MAX;
                    n_max   = '0;
                    n_sum   = '0;
                    n_count = '0;
                end else if (win_full) begin
                    // Key calibrated: move to the next key after a release.
                    n_phase = akl_pkg::PH_WAIT_RELEASE;
                    n_min   = akl_pkg::SAMPLE_MAX;
                    n_max   = '0;
                    n_sum   = '0;
                    n_count = '0;
                    n_key   = (r_key == KEY_LAST) ? '0 : r_key + akl_pkg::KEY_W'(1);
                end else begin
                    n_min   = win_min;
                    n_max   = win_max;
                    n_sum   = win_sum;
                    n_count = win_count;
                end
            end
            default: begin
                n_phase = akl_pkg::PH_WAIT_RELEASE;
            end
        endcase
    end

    // Input register and calibration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= akl_pkg::PH_WAIT_RELEASE;
            r_min      <= akl_pkg::SAMPLE_MAX;
            r_max      <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_key      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= i_sample.valid;
            end
            if (a_go) begin
                r_phase <= n_phase;
                r_min   <= n_min;
                r_max   <= n_max;
                r_sum   <= n_sum;
                r_count <= n_count;
                r_key   <= n_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_sample.data.sample;
        end
    end

    // Middle stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_free) begin
            r_mid_valid <= emit && a_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_free && emit) begin
            r_mid_sum  <= win_sum;
            r_mid_key  <= r_key;
            r_mid_last <= r_key == KEY_LAST;
        end
    end

    // Divide the window sum by its length through a scaled reciprocal.
    assign product = PROD_W'(r_mid_sum) * PROD_W'(RECIP_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_mid_valid) begin
            r_out.average   <= product[DIV_SHIFT +: akl_pkg::SAMPLE_W];
            r_out.key_index <= r_mid_key;
            r_out.last_key  <= r_mid_last;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule
